@@ rtl/dilp_pkg.sv @@
// ----------------------------------------------------------------------------
// dilp_pkg
// Shared constants and types for the decimal integer list parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dilp_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned MAX_END_LEN    = 8;
  localparam int unsigned POS_W          = 4;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned FIELD_W        = 32;
  localparam int unsigned PATTERN_W      = 64;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned OUT_DATA_W     = 72;

  localparam logic [CFG_IDX_W-1:0] REG_END_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_MAX = 2'd2;

  localparam logic [PATTERN_W-1:0] END_PATTERN_RST = '0;
  localparam logic [POS_W-1:0]     END_LENGTH_RST  = 4'd1;
  localparam logic [FIELD_W-1:0]   INITIAL_MAX_RST = 32'h8000_0000;

  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic             is_term;
    logic             done;
    logic [POS_W-1:0] pos_next;
  } match_t;

endpackage

`default_nettype wire

@@ rtl/dilp_end_match.sv @@
// ----------------------------------------------------------------------------
// dilp_end_match
// Terminator string matcher: compares one byte against the expected
// terminator byte and advances or restarts the match position.
// ----------------------------------------------------------------------------
`default_nettype none

module dilp_end_match (
  input  wire logic [dilp_pkg::BYTE_W-1:0]    byte_i,
  input  wire logic [dilp_pkg::POS_W-1:0]     pos_i,
  input  wire logic [dilp_pkg::PATTERN_W-1:0] end_pattern_i,
  input  wire logic [dilp_pkg::POS_W-1:0]     end_length_i,
  output dilp_pkg::match_t                    match_o
);

  logic [dilp_pkg::POS_W-1:0]  len;
  logic [dilp_pkg::POS_W-1:0]  pos;
  logic [dilp_pkg::POS_W-1:0]  pos_inc;
  logic [2:0]                  sel;
  logic [dilp_pkg::BYTE_W-1:0] term;

  always_comb begin
    if (end_length_i == '0) begin
      len = dilp_pkg::POS_W'(1);
    end else if (end_length_i > dilp_pkg::POS_W'(dilp_pkg::MAX_END_LEN)) begin
      len = dilp_pkg::POS_W'(dilp_pkg::MAX_END_LEN);
    end else begin
      len = end_length_i;
    end
    // stale position after a length change restarts the match
    pos  = (pos_i >= len) ? '0 : pos_i;
    sel  = pos[2:0];
    term = end_pattern_i[8*sel +: 8];
    match_o.is_term = (byte_i == term);
    pos_inc = match_o.is_term ? pos + dilp_pkg::POS_W'(1) : '0;
    match_o.done     = (pos_inc >= len);
    match_o.pos_next = match_o.done ? '0 : pos_inc;
  end

endmodule

`default_nettype wire

@@ rtl/decimal_int_list_parser_core.sv @@
// ----------------------------------------------------------------------------
// decimal_int_list_parser_core
// Parses space-separated signed decimal integers from a byte stream, closed
// by a programmable terminator string; emits each value with a running max.
// ----------------------------------------------------------------------------
//  channel   dir  transaction payload
//  s_axis    in   one text byte
//  m_axis    out  parse result, tuser has_value, tlast marks terminator completion
//  cfg       in   register write (end_pattern, end_length, initial_max)
//
//  One byte per cycle sustained while the output is not stalled; each accepted
//  byte passes the input register, then parse logic into the result register.
//  The parse state is updated when a byte leaves the input register, which
//  happens only while the result register is empty or being drained.
//  Reset loads the running max from the initial_max reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_int_list_parser_core #(
  parameter int unsigned VALUE_BITS = dilp_pkg::VALUE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,  // byte_in[7:0]
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // value[31:0], running_max[63:32], overflow[64], zero pad
  output logic [dilp_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tuser,  // has_value[0]
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_we_i,
  input  wire logic [dilp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [dilp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned VB  = VALUE_BITS;
  localparam int unsigned AW  = VALUE_BITS + 4;
  localparam logic [63:0] MAX_RST64 = 64'(signed'(dilp_pkg::INITIAL_MAX_RST));
  localparam logic [AW-1:0] SIGNB = AW'(1) << (VB - 1);

  // configuration
  logic [dilp_pkg::PATTERN_W-1:0] end_pattern_q;
  logic [dilp_pkg::POS_W-1:0]     end_length_q;

  // parse state
  logic [dilp_pkg::POS_W-1:0] pos_q, pos_d;
  logic [VB-1:0]              acc_q, acc_d;
  logic                       neg_q, neg_d;
  logic                       started_q, started_d;
  logic                       seen_q, seen_d;
  logic                       closed_q, closed_d;
  logic                       sat_q, sat_d;
  logic [VB-1:0]              max_q, max_d;

  // input register
  logic                        in_valid_q;
  logic [dilp_pkg::BYTE_W-1:0] in_byte_q;

  // result register
  logic                        out_valid_q, out_valid_d;
  logic                        has_value_q, has_value_d;
  logic [dilp_pkg::FIELD_W-1:0] value_q, value_d;
  logic [dilp_pkg::FIELD_W-1:0] rmax_q, rmax_d;
  logic                        ovf_q, ovf_d;
  logic                        last_q, last_d;

  logic advance;
  logic in_take;

  dilp_pkg::match_t match;

  dilp_end_match u_end_match (
    .byte_i        (in_byte_q),
    .pos_i         (pos_q),
    .end_pattern_i (end_pattern_q),
    .end_length_i  (end_length_q),
    .match_o       (match)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // token logic
  logic          is_space;
  logic          take_space;
  logic          f_acc_neg, f_started, f_seen, f_closed, f_sat;
  logic [VB-1:0] f_acc;
  logic          is_digit;
  logic [3:0]    digit;
  logic [AW-1:0] acc_ext, prod, limit;
  logic          src_neg, src_sat;
  logic [VB-1:0] src_acc, v, max1, max_sel;
  logic          take_v;
  logic [63:0]   v64, max64;

  always_comb begin
    is_space   = (in_byte_q == dilp_pkg::CHAR_SPACE);
    take_space = is_space && seen_q;
    is_digit   = (in_byte_q >= dilp_pkg::CHAR_ZERO) && (in_byte_q <= dilp_pkg::CHAR_NINE);
    digit      = in_byte_q[3:0];

    f_acc     = acc_q;
    f_acc_neg = neg_q;
    f_started = started_q;
    f_seen    = seen_q;
    f_closed  = closed_q;
    f_sat     = sat_q;

    acc_ext = AW'(acc_q);
    prod    = (acc_ext << 3) + (acc_ext << 1) + AW'(digit);
    limit   = SIGNB;

    if (!match.is_term && !is_space && !closed_q) begin
      if (!started_q && (in_byte_q >= dilp_pkg::CHAR_TAB) && (in_byte_q <= dilp_pkg::CHAR_CR)) begin
        f_started = 1'b0;
      end else if (!started_q &&
                   ((in_byte_q == dilp_pkg::CHAR_PLUS) || (in_byte_q == dilp_pkg::CHAR_MINUS))) begin
        f_started = 1'b1;
        f_acc_neg = (in_byte_q == dilp_pkg::CHAR_MINUS);
      end else begin
        f_started = 1'b1;
        if (is_digit) begin
          f_seen = 1'b1;
          limit  = neg_q ? SIGNB : SIGNB - AW'(1);
          if (!sat_q) begin
            if (prod > limit) begin
              f_acc = limit[VB-1:0];
              f_sat = 1'b1;
            end else begin
              f_acc = prod[VB-1:0];
            end
          end
        end else begin
          f_closed = 1'b1;
        end
      end
    end

    // value source: pending token on a space, fed token on completion
    src_acc = is_space ? acc_q : f_acc;
    src_neg = is_space ? neg_q : f_acc_neg;
    src_sat = is_space ? sat_q : f_sat;
    v       = src_neg ? (VB'(0) - src_acc) : src_acc;
    take_v  = take_space || (match.done && f_seen && !is_space);
    max_sel = ($signed(v) > $signed(max_q)) ? v : max_q;
    max1    = take_v ? max_sel : max_q;
    v64     = 64'(v);
    max64   = 64'(max1);

    has_value_d = take_v;
    value_d     = take_v ? v64[dilp_pkg::FIELD_W-1:0] : '0;
    ovf_d       = take_v && src_sat;
    rmax_d      = max64[dilp_pkg::FIELD_W-1:0];
    last_d      = match.done;

    max_d = max1;
    pos_d = match.pos_next;
    if (is_space || match.done) begin
      acc_d     = '0;
      neg_d     = 1'b0;
      started_d = 1'b0;
      seen_d    = 1'b0;
      closed_d  = 1'b0;
      sat_d     = 1'b0;
    end else begin
      acc_d     = f_acc;
      neg_d     = f_acc_neg;
      started_d = f_started;
      seen_d    = f_seen;
      closed_d  = f_closed;
      sat_d     = f_sat;
    end

    if (advance) begin
      out_valid_d = take_v || match.done;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_pattern_q <= dilp_pkg::END_PATTERN_RST;
      end_length_q  <= dilp_pkg::END_LENGTH_RST;
      pos_q         <= '0;
      acc_q         <= '0;
      neg_q         <= 1'b0;
      started_q     <= 1'b0;
      seen_q        <= 1'b0;
      closed_q      <= 1'b0;
      sat_q         <= 1'b0;
      max_q         <= MAX_RST64[VB-1:0];
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
      if (advance) begin
        pos_q     <= pos_d;
        acc_q     <= acc_d;
        neg_q     <= neg_d;
        started_q <= started_d;
        seen_q    <= seen_d;
        closed_q  <= closed_d;
        sat_q     <= sat_d;
      end
      if (cfg_we_i && (cfg_idx_i == dilp_pkg::REG_INITIAL_MAX)) begin
        max_q <= VB'(64'(signed'(cfg_wdata_i[dilp_pkg::FIELD_W-1:0])));
      end else if (advance) begin
        max_q <= max_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dilp_pkg::REG_END_PATTERN: begin
            end_pattern_q <= cfg_wdata_i;
          end
          dilp_pkg::REG_END_LENGTH: begin
            end_length_q <= cfg_wdata_i[dilp_pkg::POS_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      has_value_q <= has_value_d;
      value_q     <= value_d;
      rmax_q      <= rmax_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, ovf_q, rmax_q, value_q};
  assign m_axis_tuser  = has_value_q;
  assign m_axis_tlast  = last_q;

  a_no_value_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("result without value is not a list end");

  a_ovf_has_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[64] |-> m_axis_tuser)
    else $error("overflow flagged without a value");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < dilp_pkg::POS_W'(dilp_pkg::MAX_END_LEN))
    else $error("match position out of range");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready && !cfg_we_i |=> $stable(max_q) && $stable(acc_q))
    else $error("parse state moved while the output was stalled");

endmodule

`default_nettype wire

@@ tb/sv/decimal_int_list_parser_core_test.sv @@
// ----------------------------------------------------------------------------
// decimal_int_list_parser_core_test
// Streams text bytes into the integer list parser under several terminator
// and running-max settings, predicts every result transaction in step with
// input acceptance, and checks each output field in order. Both stream sides
// idle in random bursts; one long receiver hold backs up the input.
// ----------------------------------------------------------------------------

module decimal_int_list_parser_core_test;

  typedef struct packed {
    logic               has_value;
    logic signed [31:0] value;
    logic signed [31:0] running_max;
    logic               overflow;
    logic               last;
  } parse_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata = '0;    // byte_in[7:0]
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // value[31:0], running_max[63:32], overflow[64], zero pad
  logic [dilp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;         // has_value[0]
  logic                            m_axis_tlast;
  logic                            cfg_we_i = 1'b0;
  logic [dilp_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [dilp_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  decimal_int_list_parser_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // parser model: configuration and state
  logic [dilp_pkg::PATTERN_W-1:0] end_pattern = dilp_pkg::END_PATTERN_RST;
  logic [dilp_pkg::POS_W-1:0]     end_len     = dilp_pkg::END_LENGTH_RST;
  logic [dilp_pkg::POS_W-1:0]     match_pos   = '0;
  bit [63:0]                      magnitude   = '0;
  bit                   negative, token_started, digits_seen, digits_closed, saturated;
  logic signed [31:0]             max_so_far  = dilp_pkg::INITIAL_MAX_RST;

  logic [7:0]    text_q[$];
  parse_result_t parsed_q[$];

  int  fail_count = 0;
  bit  byte_taken = 1'b0;
  bit  quiet = 1'b0;
  bit  send_calm = 1'b0;
  bit  recv_calm = 1'b0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  hold_reqs = 0;
  int  holds_done = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(20 * 400000);
    $display("decimal_int_list_parser_core_test: errors");
    $finish;
  end

  function automatic int unsigned eff_len();
    if (end_len == 0) return 1;
    if (end_len > dilp_pkg::MAX_END_LEN) return dilp_pkg::MAX_END_LEN;
    return end_len;
  endfunction

  function automatic void clear_token();
    magnitude     = '0;
    negative      = 1'b0;
    token_started = 1'b0;
    digits_seen   = 1'b0;
    digits_closed = 1'b0;
    saturated     = 1'b0;
  endfunction

  function automatic void take_value(inout parse_result_t r);
    logic signed [31:0] v;
    v = negative ? 32'(-magnitude) : 32'(magnitude);
    if (v > max_so_far) max_so_far = v;
    r.has_value   = 1'b1;
    r.value       = v;
    r.running_max = max_so_far;
    r.overflow    = saturated;
  endfunction

  // returns 1 when the byte yields a result transaction
  function automatic bit parse_byte(input logic [7:0] c, output parse_result_t r);
    int unsigned len, pos;
    logic [7:0]  term;
    bit          got;
    bit [63:0]   lim;
    len = eff_len();
    pos = match_pos;
    if (pos >= len) pos = 0;
    term = end_pattern[8*pos +: 8];
    r = '0;
    r.running_max = max_so_far;
    got = 1'b0;
    if (c == dilp_pkg::CHAR_SPACE) begin
      if (digits_seen) begin
        take_value(r);
        got = 1'b1;
      end
      clear_token();
    end
    if (c == term) begin
      pos++;
    end else begin
      pos = 0;
      if (c != dilp_pkg::CHAR_SPACE && !digits_closed &&
          (token_started || c < dilp_pkg::CHAR_TAB || c > dilp_pkg::CHAR_CR)) begin
        if (!token_started && (c == dilp_pkg::CHAR_PLUS || c == dilp_pkg::CHAR_MINUS)) begin
          token_started = 1'b1;
          negative = (c == dilp_pkg::CHAR_MINUS);
        end else begin
          token_started = 1'b1;
          if (c >= dilp_pkg::CHAR_ZERO && c <= dilp_pkg::CHAR_NINE) begin
            lim = negative ? 64'h8000_0000 : 64'h7FFF_FFFF;
            digits_seen = 1'b1;
            if (!saturated) begin
              if (magnitude > (lim - (c - dilp_pkg::CHAR_ZERO)) / 10) begin
                magnitude = lim;
                saturated = 1'b1;
              end else begin
                magnitude = magnitude * 10 + (c - dilp_pkg::CHAR_ZERO);
              end
            end
          end else begin
            digits_closed = 1'b1;
          end
        end
      end
    end
    if (pos >= len) begin
      if (digits_seen) take_value(r);
      r.running_max = max_so_far;
      r.last = 1'b1;
      clear_token();
      match_pos = '0;
      return 1'b1;
    end
    match_pos = dilp_pkg::POS_W'(pos);
    return got;
  endfunction

  // text generation
  function automatic void queue_byte(logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic void push_token();
    int unsigned r;
    longint unsigned big;
    r = $urandom_range(0, 19);
    if ($urandom_range(0, 5) == 0) queue_byte(8'($urandom_range(9, 13)));
    case ($urandom_range(0, 3))
      0: queue_byte(dilp_pkg::CHAR_MINUS);
      1: queue_byte(dilp_pkg::CHAR_PLUS);
      default: ;
    endcase
    if (r < 12) begin
      push_str($sformatf("%0d", $urandom_range(0, 99999)));
    end else if (r < 14) begin
      big = {$urandom, $urandom};
      push_str($sformatf("%0d", big));
    end else if (r == 14) begin
      push_str($sformatf("%0d", 64'd2147483647 + $urandom_range(0, 2)));
    end else if (r == 15) begin
      push_str("0000000000012");
    end else if (r == 17) begin
      push_str($sformatf("%0dx%0d", $urandom_range(0, 999), $urandom_range(0, 99)));
    end else if (r == 18) begin
      repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
    end else if (r == 19) begin
      push_str($sformatf("%0d", $urandom));
    end
    // r == 16 leaves a digitless token
    if ($urandom_range(0, 9) != 0)
      repeat ($urandom_range(1, 2)) queue_byte(dilp_pkg::CHAR_SPACE);
  endfunction

  function automatic void push_list();
    int n, k;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) push_token();
    k = eff_len();
    if ($urandom_range(0, 7) == 0) k = $urandom_range(0, k - 1);
    for (int i = 0; i < k; i++) queue_byte(end_pattern[8*i +: 8]);
  endfunction

  function automatic void fill_text(int nbytes);
    while (text_q.size() < nbytes) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 8)) queue_byte(8'($urandom_range(0, 255)));
      end else begin
        push_list();
      end
    end
  endfunction

  task automatic write_reg(logic [dilp_pkg::CFG_IDX_W-1:0] idx,
                           logic [dilp_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      dilp_pkg::REG_END_PATTERN: end_pattern = data;
      dilp_pkg::REG_END_LENGTH:  end_len = data[dilp_pkg::POS_W-1:0];
      dilp_pkg::REG_INITIAL_MAX: max_so_far = data[dilp_pkg::FIELD_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(logic [63:0] pat, logic [3:0] len, logic [31:0] init);
    write_reg(dilp_pkg::REG_END_PATTERN, pat);
    write_reg(dilp_pkg::REG_END_LENGTH, 64'(len));
    write_reg(dilp_pkg::REG_INITIAL_MAX, 64'(init));
  endtask

  task automatic drain();
    while (text_q.size() != 0 || s_axis_tvalid || parsed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // input side driver
  always @(negedge clk_i) begin : drive_text
    logic       nv;
    logic [7:0] nd;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
    if (!s_axis_tvalid || byte_taken) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (!quiet && !send_calm && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 4);
      end else if (text_q.size() > 0) begin
        nv = 1'b1;
        nd = text_q.pop_front();
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata  <= nd;
  end

  // output side ready
  always @(negedge clk_i) begin : drive_ready
    logic nr;
    nr = 1'b1;
    if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
    if (hold_reqs != holds_done) begin
      holds_done++;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      hold_left--;
      nr = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      nr = 1'b0;
    end else if (!quiet && !recv_calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      nr = 1'b0;
    end
    m_axis_tready <= nr;
  end

  always @(posedge clk_i) begin : watch_text
    parse_result_t r;
    byte_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (parse_byte(s_axis_tdata, r)) parsed_q.insert(parsed_q.size(), r);
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    parse_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (parsed_q.size() == 0) begin
        $error("unexpected result transaction: tdata=%h tuser=%b tlast=%b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        fail_count++;
      end else begin
        want = parsed_q.pop_front();
        check_field("has_value", want.has_value, m_axis_tuser);
        check_field("value", $signed(want.value), $signed(m_axis_tdata[31:0]));
        check_field("running_max", $signed(want.running_max), $signed(m_axis_tdata[63:32]));
        check_field("overflow", want.overflow, m_axis_tdata[64]);
        check_field("last", want.last, m_axis_tlast);
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: single NUL terminator
    push_str("\t+5  -x 3000000000 1a");
    queue_byte(8'hFF);
    queue_byte(8'h00);
    drain();

    // leave a partial terminator pending, then shrink the length under it
    set_config(64'h0A44_4E45, 4'd4, 32'h0);
    push_str(" 42 EN");
    drain();

    set_config(64'h3B, 4'd1, 32'h7FFF_FFFF);
    hold_reqs++;
    fill_text(180);
    drain();

    set_config(64'h0A44_4E45, 4'd4, 32'h0);
    fill_text(180);
    drain();

    set_config(64'h2D46_4F45_2D2D_0A0D, 4'd8, 32'h8000_0000);
    fill_text(200);
    drain();

    set_config(64'hDEAD_BEEF_0000_3B20, 4'd2, $urandom);
    fill_text(150);
    drain();

    set_config(64'h20, 4'd1, 32'hFFFF_FFFB);
    fill_text(120);
    drain();

    set_config('1, 4'd0, $urandom);
    fill_text(120);
    drain();

    set_config({$urandom, $urandom}, 4'd15, $urandom);
    fill_text(100);
    drain();

    quiet = 1'b1;
    set_config(64'h0A, 4'd1, $urandom);
    fill_text(150);
    drain();

    if (fail_count == 0) begin
      $display("decimal_int_list_parser_core_test: clean");
    end else begin
      $display("decimal_int_list_parser_core_test: errors");
    end
    $finish;
  end

endmodule
